/* sv/assert_macros.svh */
// Assertion macros shared by the closest-point block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CPT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CPT_ASSERT(lbl, clk, rst, prop, msg)
`define CPT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* sv/cpt_pkg.sv */
// Shared types and constants of the closest-point-on-triangle block.
`default_nettype none
package cpt_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int Q_DEPTH         = 4;

  // Region of the triangle that holds the nearest point.
  typedef enum logic [2:0] {
    REG_VA   = 3'd0,
    REG_VB   = 3'd1,
    REG_VC   = 3'd2,
    REG_AB   = 3'd3,
    REG_BC   = 3'd4,
    REG_AC   = 3'd5,
    REG_FACE = 3'd6
  } region_t;

  // Control that travels with each classified transaction.
  typedef struct packed {
    logic    vld;
    region_t code;
  } tag_t;

endpackage
`default_nettype wire

/* sv/cpt_front.sv */
// Front end: differences, dot products, cross terms and region classification.
`default_nettype none
module cpt_front import cpt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int EW = 3 * (4 * (CW + 1) + 5) + 3 * CW + 6 * (CW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic signed [CW-1:0] crd [12],
  output tag_t                 tag,
  output logic [EW-1:0]        data
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int HW  = (SW + 1) / 2;
  localparam int PPW = 2 * HW;
  localparam int XW  = 2 * SW;
  localparam int NW  = XW + 3;
  localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

  logic [7:1] vld;
  logic signed [CW-1:0] vtx [1:6][9];
  logic signed [DW-1:0] edg [1:6][9];
  logic signed [DW-1:0] pv1 [9];
  logic signed [PW-1:0] pr2 [6][3];
  logic signed [SW-1:0] dt [3:6][6];
  logic [PPW-1:0] pp4 [6][4];
  logic sg4 [6];
  logic signed [XW-1:0] xp5 [6];
  logic signed [NW-1:0] va6, vb6, vc6;
  logic [PPW-1:0] maga [6];
  logic [PPW-1:0] magb [6];
  logic [XW-1:0] mw [6];

  region_t code_next, code7;
  logic signed [NW-1:0] num0_next, num1_next, den_next, num07, num17, den7;
  logic signed [CW-1:0] base_next [3];
  logic signed [CW-1:0] base7 [3];
  logic signed [DW-1:0] dir0_next [3];
  logic signed [DW-1:0] dir1_next [3];
  logic signed [DW-1:0] dir07 [3];
  logic signed [DW-1:0] dir17 [3];

  function automatic logic [PPW-1:0] mag_of(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    return PPW'(m);
  endfunction

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:1], take};
    end
  end

  // Magnitudes of the dot products that feed the cross terms.
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      maga[m] = mag_of(dt[3][PA[m]]);
      magb[m] = mag_of(dt[3][PB[m]]);
    end
  end

  // Recombine the partial products.
  always_comb begin
    for (int m = 0; m < 6; m++) begin
      mw[m] = (XW'(pp4[m][3]) << (2 * HW)) + ((XW'(pp4[m][1]) + XW'(pp4[m][2])) << HW)
              + XW'(pp4[m][0]);
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      vtx[1][k]     <= crd[3 + k];
      vtx[1][3 + k] <= crd[6 + k];
      vtx[1][6 + k] <= crd[9 + k];
      edg[1][k]     <= DW'(crd[6 + k]) - DW'(crd[3 + k]);
      edg[1][3 + k] <= DW'(crd[9 + k]) - DW'(crd[3 + k]);
      edg[1][6 + k] <= DW'(crd[9 + k]) - DW'(crd[6 + k]);
      pv1[k]        <= DW'(crd[k]) - DW'(crd[3 + k]);
      pv1[3 + k]    <= DW'(crd[k]) - DW'(crd[6 + k]);
      pv1[6 + k]    <= DW'(crd[k]) - DW'(crd[9 + k]);
    end
    for (int s = 2; s <= 6; s++) begin
      vtx[s] <= vtx[s - 1];
      edg[s] <= edg[s - 1];
    end
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        pr2[j][k] <= PW'(edg[1][(j % 2) * 3 + k]) * PW'(pv1[(j / 2) * 3 + k]);
      end
      dt[3][j] <= SW'(pr2[j][0]) + SW'(pr2[j][1]) + SW'(pr2[j][2]);
    end
    for (int s = 4; s <= 6; s++) begin
      dt[s] <= dt[s - 1];
    end
    for (int m = 0; m < 6; m++) begin
      pp4[m][0] <= PPW'(maga[m][HW-1:0]) * PPW'(magb[m][HW-1:0]);
      pp4[m][1] <= PPW'(maga[m][HW-1:0]) * PPW'(magb[m][PPW-1:HW]);
      pp4[m][2] <= PPW'(maga[m][PPW-1:HW]) * PPW'(magb[m][HW-1:0]);
      pp4[m][3] <= PPW'(maga[m][PPW-1:HW]) * PPW'(magb[m][PPW-1:HW]);
      sg4[m]    <= dt[3][PA[m]][SW-1] ^ dt[3][PB[m]][SW-1];
      xp5[m]    <= sg4[m] ? $signed(-mw[m]) : $signed(mw[m]);
    end
    vc6 <= NW'(xp5[0]) - NW'(xp5[1]);
    vb6 <= NW'(xp5[2]) - NW'(xp5[3]);
    va6 <= NW'(xp5[4]) - NW'(xp5[5]);
    code7 <= code_next;
    num07 <= num0_next;
    num17 <= num1_next;
    den7  <= den_next;
    base7 <= base_next;
    dir07 <= dir0_next;
    dir17 <= dir1_next;
  end

  // Voronoi region tests, in the order vertex a, b, edge ab, c, ac, bc, face.
  always_comb begin
    logic signed [SW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [NW-1:0] nbc;
    d1 = dt[6][0];
    d2 = dt[6][1];
    d3 = dt[6][2];
    d4 = dt[6][3];
    d5 = dt[6][4];
    d6 = dt[6][5];
    nbc = NW'(d4) - NW'(d3);
    code_next = REG_FACE;
    num0_next = vb6;
    num1_next = vc6;
    den_next  = va6 + vb6 + vc6;
    for (int k = 0; k < 3; k++) begin
      base_next[k] = vtx[6][k];
      dir0_next[k] = edg[6][k];
      dir1_next[k] = edg[6][3 + k];
    end
    if (d1 <= 0 && d2 <= 0) begin
      code_next = REG_VA;
      num0_next = '0;
      num1_next = '0;
      den_next  = '0;
    end else if (d3 >= 0 && d4 <= d3) begin
      code_next = REG_VB;
      num0_next = '0;
      num1_next = '0;
      den_next  = '0;
      for (int k = 0; k < 3; k++) base_next[k] = vtx[6][3 + k];
    end else if (vc6 <= 0 && d1 >= 0 && d3 <= 0) begin
      code_next = REG_AB;
      num0_next = NW'(d1);
      num1_next = '0;
      den_next  = NW'(d1) - NW'(d3);
    end else if (d6 >= 0 && d5 <= d6) begin
      code_next = REG_VC;
      num0_next = '0;
      num1_next = '0;
      den_next  = '0;
      for (int k = 0; k < 3; k++) base_next[k] = vtx[6][6 + k];
    end else if (vb6 <= 0 && d2 >= 0 && d6 <= 0) begin
      code_next = REG_AC;
      num0_next = NW'(d2);
      num1_next = '0;
      den_next  = NW'(d2) - NW'(d6);
      for (int k = 0; k < 3; k++) dir0_next[k] = edg[6][3 + k];
    end else if (va6 <= 0 && d4 >= d3 && d5 >= d6) begin
      code_next = REG_BC;
      num0_next = nbc;
      num1_next = '0;
      den_next  = nbc + NW'(d5) - NW'(d6);
      for (int k = 0; k < 3; k++) begin
        base_next[k] = vtx[6][3 + k];
        dir0_next[k] = edg[6][6 + k];
      end
    end
  end

  assign tag.vld  = vld[7];
  assign tag.code = code7;
  assign data = {num07, num17, den7, base7[0], base7[1], base7[2],
                 dir07[0], dir07[1], dir07[2], dir17[0], dir17[1], dir17[2]};

endmodule
`default_nettype wire

/* sv/cpt_queue.sv */
// Short queue between the classifier and the projection back end.
`default_nettype none
module cpt_queue import cpt_pkg::*; #(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  tag_t          in_tag,
  input  logic [EW-1:0] in_data,
  output tag_t          out_tag,
  output logic [EW-1:0] out_data,
  output logic          full
);

  localparam int PTRW = $clog2(Q_DEPTH);
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  logic [EW-1:0] mem [Q_DEPTH];
  region_t code_mem [Q_DEPTH];
  logic [PTRW-1:0] wr, rd;
  logic [CNTW-1:0] count;
  logic push, pop;
  logic out_vld;
  region_t out_code;

  assign push = in_tag.vld;
  assign pop  = (count != '0);
  assign full = (count == CNTW'(Q_DEPTH));
  assign out_tag = '{vld: out_vld, code: out_code};

  // Pointers, fill count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
      out_vld <= 1'b0;
    end else begin
      if (push) begin
        wr <= (wr == PTRW'(Q_DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == PTRW'(Q_DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
      out_vld <= pop;
    end
  end

  // Storage and registered read port.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= in_data;
      code_mem[wr] <= in_tag.code;
    end
    if (pop) begin
      out_data <= mem[rd];
      out_code <= code_mem[rd];
    end
  end

endmodule
`default_nettype wire

/* sv/cpt_back.sv */
// Back end: pipelined barycentric division, scaling and saturating sum.
`default_nettype none
module cpt_back import cpt_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF,
  parameter int EW = 3 * (4 * (CW + 1) + 5) + 3 * CW + 6 * (CW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tag_t                 in_tag,
  input  logic [EW-1:0]        in_data,
  output logic signed [CW-1:0] near [3],
  output region_t              code,
  output logic                 done
);

  localparam int DW   = CW + 1;
  localparam int NW   = 4 * DW + 5;
  localparam int SCW  = FB + 2 + DW;
  localparam int OW   = CW + 2;
  localparam int SUMW = CW + 3;
  localparam logic signed [SUMW-1:0] MAXV = {{(SUMW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] MINV = ~MAXV;

  logic signed [NW-1:0] num0, num1, den;
  logic signed [CW-1:0] base_in [3];
  logic signed [DW-1:0] d0_in [3];
  logic signed [DW-1:0] d1_in [3];

  logic [FB:0] vld;
  logic [NW-1:0] rem [2][FB+1];
  logic [NW-1:0] dsr [FB+1];
  logic [FB-1:0] qb [2][FB+1];
  logic zr [2][FB+1];
  logic on [2][FB+1];
  logic signed [CW-1:0] base [FB+1][3];
  logic signed [DW-1:0] dir [2][FB+1][3];
  region_t cd [FB+1];
  logic [NW:0] r2 [2][1:FB];
  logic ge [2][1:FB];
  logic [FB:0] qf [2];

  logic sc_vld;
  region_t sc_code;
  logic signed [CW-1:0] sc_base [3];
  logic signed [OW-1:0] off [2][3];
  logic signed [SUMW-1:0] sum [3];

  assign {num0, num1, den, base_in[0], base_in[1], base_in[2],
          d0_in[0], d0_in[1], d0_in[2], d1_in[0], d1_in[1], d1_in[2]} = in_data;

  // One quotient bit per stage and lane.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int s = 1; s <= FB; s++) begin
        r2[l][s] = {rem[l][s - 1], 1'b0};
        ge[l][s] = (r2[l][s] >= {1'b0, dsr[s - 1]});
      end
      qf[l] = zr[l][FB] ? '0 : (on[l][FB] ? {1'b1, {FB{1'b0}}} : {1'b0, qb[l][FB]});
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sc_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      vld <= {vld[FB-1:0], in_tag.vld};
      sc_vld <= vld[FB];
      done <= sc_vld;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    // Weight outside (0, 1) is settled up front; else start the remainder.
    zr[0][0] <= num0[NW-1] || num0 == '0 || den[NW-1] || den == '0;
    zr[1][0] <= num1[NW-1] || num1 == '0 || den[NW-1] || den == '0;
    on[0][0] <= num0 >= den;
    on[1][0] <= num1 >= den;
    rem[0][0] <= num0;
    rem[1][0] <= num1;
    qb[0][0] <= '0;
    qb[1][0] <= '0;
    dsr[0] <= den;
    base[0] <= base_in;
    dir[0][0] <= d0_in;
    dir[1][0] <= d1_in;
    cd[0] <= in_tag.code;
    for (int s = 1; s <= FB; s++) begin
      for (int l = 0; l < 2; l++) begin
        rem[l][s] <= ge[l][s] ? NW'(r2[l][s] - {1'b0, dsr[s - 1]}) : NW'(r2[l][s]);
        qb[l][s] <= {qb[l][s - 1][FB-2:0], ge[l][s]};
        zr[l][s] <= zr[l][s - 1];
        on[l][s] <= on[l][s - 1];
        dir[l][s] <= dir[l][s - 1];
      end
      dsr[s] <= dsr[s - 1];
      base[s] <= base[s - 1];
      cd[s] <= cd[s - 1];
    end
    // Offsets rounded toward minus infinity.
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < 3; k++) begin
        off[l][k] <= OW'((SCW'($signed({1'b0, qf[l]})) * SCW'(dir[l][FB][k])) >>> FB);
      end
    end
    sc_base <= base[FB];
    sc_code <= cd[FB];
    // Sum and clamp to the coordinate range.
    for (int k = 0; k < 3; k++) begin
      if (sum[k] > MAXV) begin
        near[k] <= MAXV[CW-1:0];
      end else if (sum[k] < MINV) begin
        near[k] <= MINV[CW-1:0];
      end else begin
        near[k] <= sum[k][CW-1:0];
      end
    end
    code <= sc_code;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUMW'(sc_base[k]) + SUMW'(off[0][k]) + SUMW'(off[1][k]);
    end
  end

endmodule
`default_nettype wire

/* sv/closest_point_on_triangle.sv */
// Top level of the closest-point-on-triangle block.
//
//   channel   | handshake         | payload
//   ----------+-------------------+--------------------------------------------
//   command   | start / busy      | query_*, vert_a_*, vert_b_*, vert_c_*
//   result    | done (one cycle)  | near_x, near_y, near_z, region_code
//
// One transaction is taken per cycle while busy is low; each result passes seven
// classifier stages, two through the queue, and the one-bit-per-stage divider
// plus scale and sum stages in the back end.
// Reset is synchronous and clears all valid bits and the queue pointers.
// busy rises only when the queue is full; the back end drains it every cycle.
`default_nettype none
`include "assert_macros.svh"
module closest_point_on_triangle import cpt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] query_x,
  input  logic signed [COORD_WIDTH-1:0] query_y,
  input  logic signed [COORD_WIDTH-1:0] query_z,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] near_z,
  output logic [2:0]                    region_code
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = 4 * DW + 5;
  localparam int EW = 3 * NW + 3 * COORD_WIDTH + 6 * DW;
  localparam int FRONT_LAT = 7;
  localparam int BACK_LAT  = FRAC_BITS + 3;

  logic take;
  logic signed [COORD_WIDTH-1:0] crd [12];
  logic signed [COORD_WIDTH-1:0] near [3];
  tag_t f_tag, q_tag;
  logic [EW-1:0] f_data, q_data;
  region_t code;

  assign take = start && !busy;
  assign crd = '{query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
                 vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z};

  cpt_front #(.CW(COORD_WIDTH), .EW(EW)) u_front (
    .clk(clk), .rst(rst), .take(take), .crd(crd), .tag(f_tag), .data(f_data)
  );

  cpt_queue #(.EW(EW)) u_queue (
    .clk(clk), .rst(rst), .in_tag(f_tag), .in_data(f_data),
    .out_tag(q_tag), .out_data(q_data), .full(busy)
  );

  cpt_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS), .EW(EW)) u_back (
    .clk(clk), .rst(rst), .in_tag(q_tag), .in_data(q_data),
    .near(near), .code(code), .done(done)
  );

  assign near_x = near[0];
  assign near_y = near[1];
  assign near_z = near[2];
  assign region_code = code;

  // Checks on the pipeline timing and the queue.
  `CPT_ASSERT(a_front_lat, clk, rst, take |-> ##FRONT_LAT f_tag.vld, "classifier lost a transaction")
  `CPT_ASSERT(a_back_lat, clk, rst, q_tag.vld |-> ##BACK_LAT done, "back end lost a transaction")
  `CPT_NEVER(a_no_overflow, clk, rst, f_tag.vld && busy, "push into a full queue")

endmodule
`default_nettype wire
